[rtl/md5_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round functions for the MD5 digest block.
// ---------------------------------------------------------------------------
package md5_pkg;

   localparam int unsigned ByteWidth     = 8;
   localparam int unsigned WordWidth     = 32;
   localparam int unsigned CountWidth    = 61;
   localparam int unsigned LengthWidth   = 64;
   localparam int unsigned BufWords      = 16;
   localparam int unsigned WordAddrWidth = 4;
   localparam int unsigned RoundWidth    = 6;

   typedef logic [ByteWidth-1:0]     byte_type;
   typedef logic [WordWidth-1:0]     word_type;
   typedef logic [WordAddrWidth-1:0] waddr_type;
   typedef logic [RoundWidth-1:0]    round_type;

   // Chaining word initial values
   localparam word_type InitA = 32'h67452301;
   localparam word_type InitB = 32'hefcdab89;
   localparam word_type InitC = 32'h98badcfe;
   localparam word_type InitD = 32'h10325476;

   localparam byte_type  PadMarker   = 8'h80;
   localparam waddr_type LenLowWord  = 4'd14;
   localparam waddr_type LenHighWord = 4'd15;
   localparam waddr_type LastWord    = 4'd15;
   localparam round_type LastRound   = 6'd63;
   localparam logic [5:0] LastBytePos = 6'd63;
   localparam logic [1:0] LastLane    = 2'd3;
   localparam logic [2:0] LenSlot     = 3'd7;

   // Round groups
   localparam logic [1:0] GrpF = 2'd0;
   localparam logic [1:0] GrpG = 2'd1;
   localparam logic [1:0] GrpH = 2'd2;
   localparam logic [1:0] GrpI = 2'd3;

   // Additive constant of each step
   function automatic word_type step_const(input round_type idx);
      word_type k;
      case (idx)
         6'd0:  k = 32'hd76aa478;
         6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db;
         6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf;
         6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613;
         6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8;
         6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1;
         6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122;
         6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e;
         6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562;
         6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51;
         6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d;
         6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681;
         6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6;
         6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87;
         6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905;
         6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9;
         6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942;
         6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122;
         6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44;
         6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60;
         6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6;
         6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085;
         6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039;
         6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8;
         6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244;
         6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7;
         6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3;
         6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d;
         6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f;
         6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314;
         6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82;
         6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb;
         6'd63: k = 32'heb86d391;
         default: k = '0;
      endcase
      return k;
   endfunction

   // Left rotate amount, by group and low two bits of the step
   function automatic logic [4:0] rot_amount(input round_type idx);
      logic [4:0] s;
      case ({idx[5:4], idx[1:0]})
         4'd0:  s = 5'd7;
         4'd1:  s = 5'd12;
         4'd2:  s = 5'd17;
         4'd3:  s = 5'd22;
         4'd4:  s = 5'd5;
         4'd5:  s = 5'd9;
         4'd6:  s = 5'd14;
         4'd7:  s = 5'd20;
         4'd8:  s = 5'd4;
         4'd9:  s = 5'd11;
         4'd10: s = 5'd16;
         4'd11: s = 5'd23;
         4'd12: s = 5'd6;
         4'd13: s = 5'd10;
         4'd14: s = 5'd15;
         4'd15: s = 5'd21;
         default: s = '0;
      endcase
      return s;
   endfunction

   // Message word used by each step
   function automatic waddr_type msg_index(input round_type idx);
      waddr_type j;
      waddr_type g;
      j = idx[3:0];
      case (idx[5:4])
         GrpF:    g = j;
         GrpG:    g = waddr_type'(j * 4'd5 + 4'd1);
         GrpH:    g = waddr_type'(j * 4'd3 + 4'd5);
         GrpI:    g = waddr_type'(j * 4'd7);
         default: g = j;
      endcase
      return g;
   endfunction

   // Nonlinear mix of b, c, d
   function automatic word_type round_mix(input word_type b, input word_type c,
                                          input word_type d, input logic [1:0] grp);
      word_type f;
      case (grp)
         GrpF:    f = (b & c) | (~b & d);
         GrpG:    f = (b & d) | (c & ~d);
         GrpH:    f = b ^ c ^ d;
         GrpI:    f = c ^ (b | ~d);
         default: f = '0;
      endcase
      return f;
   endfunction

   function automatic word_type rotl(input word_type x, input logic [4:0] s);
      logic [2*WordWidth-1:0] dbl;
      dbl = {x, x} << s;
      return dbl[2*WordWidth-1:WordWidth];
   endfunction

endpackage
`default_nettype wire

[rtl/md5_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// md5 channel interfaces
// Valid/ready channels for message bytes and for the finished digest.
// ---------------------------------------------------------------------------
interface md5_req_if;
   logic                valid;
   logic                ready;
   md5_pkg::byte_type   data_byte;
   logic                byte_valid;
   logic                end_of_message;

   modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
   modport sink   (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

interface md5_rsp_if;
   logic                valid;
   logic                ready;
   md5_pkg::word_type   digest_word0;
   md5_pkg::word_type   digest_word1;
   md5_pkg::word_type   digest_word2;
   md5_pkg::word_type   digest_word3;

   modport source (output valid, digest_word0, digest_word1, digest_word2, digest_word3,
                   input ready);
   modport sink   (input valid, digest_word0, digest_word1, digest_word2, digest_word3,
                   output ready);
endinterface
`default_nettype wire

[rtl/md5_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// md5_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module md5_ram #(
   parameter int unsigned Width = 32,
   parameter int unsigned Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     write_en,
   input  wire logic [$clog2(Depth)-1:0] write_addr,
   input  wire logic [Width-1:0]         write_data,
   input  wire logic [$clog2(Depth)-1:0] read_addr,
   output      logic [Width-1:0]         read_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule
`default_nettype wire

[rtl/md5_message_digest.sv]
`timescale 1ns / 1ps
`default_nettype none
// Bytes are accepted while idle; a full 64-byte block then goes through compression
// (word fetch, 64 steps of the single round unit, chaining add) during which req is not ready.
// End of message: padding writes from the first pad word up to word 15 of the 16x32 buffer RAM,
// a compression per padding block, 16 zero/length writes before a second block, then a load
// of the result register (held off while an earlier digest waits).
// Reset (synchronous): chaining words to initial values, byte count zero; buffer RAM not cleared.
// ---------------------------------------------------------------------------
// md5_message_digest
// MD5 digest engine: byte collection, padding, iterative 64-step compression.
// ---------------------------------------------------------------------------
module md5_message_digest (
   input wire logic   clock,
   input wire logic   reset,
   md5_req_if.sink    req_bus,
   md5_rsp_if.source  rsp_bus
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD_START,
      ST_PAD,
      ST_LOAD,
      ST_ROUND,
      ST_FINISH,
      ST_EMIT
   } state_type;

   state_type                  state_ff, state_in;
   logic [md5_pkg::CountWidth-1:0] count_ff, count_in;
   md5_pkg::word_type          word_ff, word_in;
   md5_pkg::word_type          chain_ff [4];
   md5_pkg::word_type          chain_in [4];
   md5_pkg::word_type          a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   md5_pkg::round_type         round_ff, round_in;
   md5_pkg::waddr_type         widx_ff, widx_in;
   logic                       eom_ff, eom_in;
   logic                       pad_active_ff, pad_active_in;
   logic                       marker_done_ff, marker_done_in;
   logic                       len_here_ff, len_here_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   md5_pkg::word_type          dig0_ff, dig0_in, dig1_ff, dig1_in;
   md5_pkg::word_type          dig2_ff, dig2_in, dig3_ff, dig3_in;

   logic                       accept;
   logic [5:0]                 pos;
   md5_pkg::word_type          word_merge;
   md5_pkg::word_type          low_mask;
   md5_pkg::word_type          marker_word;
   md5_pkg::word_type          pad_word;
   logic [md5_pkg::LengthWidth-1:0] bit_length;
   md5_pkg::word_type          step_sum;
   md5_pkg::word_type          b_next;
   logic                       ram_we;
   md5_pkg::waddr_type         ram_waddr;
   md5_pkg::word_type          ram_wdata;
   md5_pkg::waddr_type         ram_raddr;
   md5_pkg::word_type          ram_rdata;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign pos           = count_ff[5:0];
   assign bit_length    = {count_ff, 3'b000};

   // Insert the incoming byte into its lane of the partial word
   always_comb begin
      word_merge = word_ff;
      word_merge[{pos[1:0], 3'b000} +: 8] = req_bus.data_byte;
   end

   // Padding words: first the collected bytes, the marker byte and zeros above, then zeros and the length
   always_comb begin
      case (pos[1:0])
         2'd0:    low_mask = 32'h00000000;
         2'd1:    low_mask = 32'h000000ff;
         2'd2:    low_mask = 32'h0000ffff;
         2'd3:    low_mask = 32'h00ffffff;
         default: low_mask = 32'h00000000;
      endcase
      marker_word = (word_ff & low_mask) |
                    (md5_pkg::word_type'(md5_pkg::PadMarker) << {pos[1:0], 3'b000});
      if (!marker_done_ff) begin
         pad_word = marker_word;
      end else if (len_here_ff && (widx_ff == md5_pkg::LenLowWord)) begin
         pad_word = bit_length[31:0];
      end else if (len_here_ff && (widx_ff == md5_pkg::LenHighWord)) begin
         pad_word = bit_length[63:32];
      end else begin
         pad_word = '0;
      end
   end

   // Shared round unit: one compression step per cycle
   assign step_sum = a_ff + md5_pkg::round_mix(b_ff, c_ff, d_ff, round_ff[5:4]) +
                     md5_pkg::step_const(round_ff) + ram_rdata;
   assign b_next   = b_ff + md5_pkg::rotl(step_sum, md5_pkg::rot_amount(round_ff));

   // Buffer RAM ports: word writes from byte collection or padding, reads one step ahead
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = widx_ff;
      ram_wdata = pad_word;
      if (state_ff == ST_PAD) begin
         ram_we = 1'b1;
      end else if (accept && req_bus.byte_valid && (pos[1:0] == md5_pkg::LastLane)) begin
         ram_we    = 1'b1;
         ram_waddr = pos[5:2];
         ram_wdata = word_merge;
      end
      if (state_ff == ST_ROUND) begin
         ram_raddr = md5_pkg::msg_index(md5_pkg::round_type'(round_ff + 6'd1));
      end else begin
         ram_raddr = md5_pkg::msg_index('0);
      end
   end

   md5_ram #(
      .Width (md5_pkg::WordWidth),
      .Depth (md5_pkg::BufWords)
   ) u_buf_ram (
      .clock      (clock),
      .write_en   (ram_we),
      .write_addr (ram_waddr),
      .write_data (ram_wdata),
      .read_addr  (ram_raddr),
      .read_data  (ram_rdata)
   );

   // Sequencer next state
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      word_in        = word_ff;
      chain_in       = chain_ff;
      a_in           = a_ff;
      b_in           = b_ff;
      c_in           = c_ff;
      d_in           = d_ff;
      round_in       = round_ff;
      widx_in        = widx_ff;
      eom_in         = eom_ff;
      pad_active_in  = pad_active_ff;
      marker_done_in = marker_done_ff;
      len_here_in    = len_here_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      dig0_in        = dig0_ff;
      dig1_in        = dig1_ff;
      dig2_in        = dig2_ff;
      dig3_in        = dig3_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               eom_in = req_bus.end_of_message;
               if (req_bus.byte_valid) begin
                  word_in  = word_merge;
                  count_in = count_ff + 61'd1;
               end
               if (req_bus.byte_valid && (pos == md5_pkg::LastBytePos)) begin
                  state_in = ST_LOAD;
               end else if (req_bus.end_of_message) begin
                  state_in = ST_PAD_START;
               end
            end
         end
         ST_PAD_START: begin
            widx_in        = pos[5:2];
            len_here_in    = (pos[5:3] != md5_pkg::LenSlot);
            marker_done_in = 1'b0;
            pad_active_in  = 1'b1;
            state_in       = ST_PAD;
         end
         ST_PAD: begin
            widx_in        = md5_pkg::waddr_type'(widx_ff + 4'd1);
            marker_done_in = 1'b1;
            if (widx_ff == md5_pkg::LastWord) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            a_in     = chain_ff[0];
            b_in     = chain_ff[1];
            c_in     = chain_ff[2];
            d_in     = chain_ff[3];
            round_in = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            a_in     = d_ff;
            b_in     = b_next;
            c_in     = b_ff;
            d_in     = c_ff;
            round_in = md5_pkg::round_type'(round_ff + 6'd1);
            if (round_ff == md5_pkg::LastRound) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            chain_in[0] = chain_ff[0] + a_ff;
            chain_in[1] = chain_ff[1] + b_ff;
            chain_in[2] = chain_ff[2] + c_ff;
            chain_in[3] = chain_ff[3] + d_ff;
            if (!pad_active_ff) begin
               state_in = eom_ff ? ST_PAD_START : ST_IDLE;
            end else if (len_here_ff) begin
               state_in = ST_EMIT;
            end else begin
               // second padding block: zeros and the length
               widx_in        = '0;
               marker_done_in = 1'b1;
               len_here_in    = 1'b1;
               state_in       = ST_PAD;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               dig0_in       = chain_ff[0];
               dig1_in       = chain_ff[1];
               dig2_in       = chain_ff[2];
               dig3_in       = chain_ff[3];
               chain_in[0]   = md5_pkg::InitA;
               chain_in[1]   = md5_pkg::InitB;
               chain_in[2]   = md5_pkg::InitC;
               chain_in[3]   = md5_pkg::InitD;
               count_in      = '0;
               eom_in        = 1'b0;
               pad_active_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         chain_ff[0]    <= md5_pkg::InitA;
         chain_ff[1]    <= md5_pkg::InitB;
         chain_ff[2]    <= md5_pkg::InitC;
         chain_ff[3]    <= md5_pkg::InitD;
         round_ff       <= '0;
         eom_ff         <= 1'b0;
         pad_active_ff  <= 1'b0;
         marker_done_ff <= 1'b0;
         len_here_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         chain_ff       <= chain_in;
         round_ff       <= round_in;
         eom_ff         <= eom_in;
         pad_active_ff  <= pad_active_in;
         marker_done_ff <= marker_done_in;
         len_here_ff    <= len_here_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      word_ff <= word_in;
      widx_ff <= widx_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      c_ff    <= c_in;
      d_ff    <= d_in;
      dig0_ff <= dig0_in;
      dig1_ff <= dig1_in;
      dig2_ff <= dig2_in;
      dig3_ff <= dig3_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.digest_word0 = dig0_ff;
   assign rsp_bus.digest_word1 = dig1_ff;
   assign rsp_bus.digest_word2 = dig2_ff;
   assign rsp_bus.digest_word3 = dig3_ff;

   // Checks
   a_round_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && round_ff == md5_pkg::LastRound) |=> (state_ff == ST_FINISH))
      else $error("compression did not end after the last step");

   a_no_write_in_compress: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> !(state_ff == ST_LOAD || state_ff == ST_ROUND || state_ff == ST_FINISH))
      else $error("buffer written during compression");

   a_reset_clean: assert property (@(posedge clock)
      reset |=> (state_ff == ST_IDLE && count_ff == '0 && !rsp_valid_ff))
      else $error("control state not cleared by reset");

   a_emit_restart: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && state_in == ST_IDLE) |=>
         (rsp_valid_ff && count_ff == '0 && chain_ff[0] == md5_pkg::InitA))
      else $error("digest emit did not restart the message");

   a_pad_len_block: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && pad_active_ff && !len_here_ff) |=> (state_ff == ST_PAD))
      else $error("second padding block skipped");

endmodule
`default_nettype wire

[dv/md5_message_digest_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// md5_message_digest_tb
// Streams random and directed messages into the MD5 engine one byte per
// transaction and compares each digest against a software MD5 kept in step
// with the accepted bytes. Both channels stall in random bursts.
// ---------------------------------------------------------------------------
module md5_message_digest_tb;

   localparam int unsigned CycleLimit = 400000;
   localparam int unsigned ItemTarget = 850;
   localparam int unsigned QuietAfter = 720;
   localparam int unsigned DrainCycles = 300;
   localparam int unsigned ShowLimit = 10;

   localparam md5_pkg::byte_type MsgPad = 8'h80;

   localparam md5_pkg::word_type InitChain [4] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};

   localparam md5_pkg::word_type StepAdd [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};

   localparam int RotLeft [16] = '{
      7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

   // word k of a digest sits in slice k
   typedef logic [3:0][31:0] digest_type;

   // Software MD5 that follows accepted transactions and queues digests
   class digest_tracker;
      md5_pkg::word_type chain [4];
      md5_pkg::byte_type block [64];
      logic [60:0]       msg_bytes;
      digest_type        digests_due [$];
      int unsigned       fail_count;

      function new();
         foreach (block[i]) block[i] = '0;
         fail_count = 0;
         restart();
      endfunction

      function void restart();
         foreach (chain[i]) chain[i] = InitChain[i];
         msg_bytes = '0;
      endfunction

      function void compress();
         md5_pkg::word_type m [16];
         md5_pkg::word_type a, b, c, d, f, t, sum;
         int g, sh;
         for (int i = 0; i < 16; i++)
            m[i] = {block[4*i+3], block[4*i+2], block[4*i+1], block[4*i]};
         a = chain[0];
         b = chain[1];
         c = chain[2];
         d = chain[3];
         for (int i = 0; i < 64; i++) begin
            case (i / 16)
               0: begin
                  f = (b & c) | (~b & d);
                  g = i;
               end
               1: begin
                  f = (b & d) | (c & ~d);
                  g = (5 * i + 1) % 16;
               end
               2: begin
                  f = b ^ c ^ d;
                  g = (3 * i + 5) % 16;
               end
               default: begin
                  f = c ^ (b | ~d);
                  g = (7 * i) % 16;
               end
            endcase
            sum = a + f + StepAdd[i] + m[g];
            sh = RotLeft[(i / 16) * 4 + i % 4];
            t = d;
            d = c;
            c = b;
            b = b + ((sum << sh) | (sum >> (32 - sh)));
            a = t;
         end
         chain[0] += a;
         chain[1] += b;
         chain[2] += c;
         chain[3] += d;
      endfunction

      // One accepted input transaction
      function void absorb(md5_pkg::byte_type data, logic byte_valid, logic msg_end);
         int pos;
         logic [63:0] bit_len;
         if (byte_valid) begin
            pos = msg_bytes[5:0];
            block[pos] = data;
            msg_bytes = msg_bytes + 1'b1;
            if (pos == 63) compress();
         end
         if (msg_end) begin
            // pad marker, zero fill, then the little-endian bit length
            pos = msg_bytes[5:0];
            block[pos] = MsgPad;
            pos++;
            if (pos > 56) begin
               for (int k = pos; k < 64; k++) block[k] = '0;
               compress();
               pos = 0;
            end
            for (int k = pos; k < 56; k++) block[k] = '0;
            bit_len = {msg_bytes, 3'b000};
            for (int k = 0; k < 8; k++) block[56+k] = bit_len[8*k +: 8];
            compress();
            digests_due.push_back({chain[3], chain[2], chain[1], chain[0]});
            restart();
         end
      endfunction

      function void flag(string msg);
         fail_count++;
         if (fail_count <= ShowLimit) $display("%0t: %s", $realtime, msg);
      endfunction

      function void compare_digest(digest_type got);
         digest_type want;
         if (digests_due.size() == 0) begin
            flag($sformatf("digest %032h with none pending", got));
            return;
         end
         want = digests_due.pop_front();
         for (int k = 0; k < 4; k++)
            if (got[k] !== want[k])
               flag($sformatf("digest_word%0d: expected %08h, got %08h",
                              k, want[k], got[k]));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   md5_req_if req_bus ();
   md5_rsp_if rsp_bus ();

   md5_message_digest dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   digest_tracker digests = new();
   bit            quiet_mode = 1'b0;
   int unsigned   items_sent = 0;
   int unsigned   cycle_count = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Digest receiver with bursty back-pressure
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready)
            digests.compare_digest({rsp_bus.digest_word3, rsp_bus.digest_word2,
                                    rsp_bus.digest_word1, rsp_bus.digest_word0});
         if (stall_left > 0)
            stall_left--;
         else if (!quiet_mode && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 7);
         rsp_bus.ready <= !reset && stall_left == 0;
      end
   end

   task automatic hold_sender(input int cycles);
      req_bus.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Drive one transaction and return once it is accepted; valid stays high
   task automatic send_item(input md5_pkg::byte_type data, input logic byte_valid,
                            input logic msg_end);
      if (!quiet_mode && $urandom_range(0, 5) == 0) hold_sender($urandom_range(1, 7));
      req_bus.valid          <= 1'b1;
      req_bus.data_byte      <= data;
      req_bus.byte_valid     <= byte_valid;
      req_bus.end_of_message <= msg_end;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      digests.absorb(data, byte_valid, msg_end);
      if (byte_valid || msg_end) items_sent++;
   endtask

   task automatic wait_for_digests();
      req_bus.valid <= 1'b0;
      while (digests.digests_due.size() != 0) @(posedge clock);
   endtask

   // Random content; end flagged on the last byte or by a separate empty item
   task automatic send_message(input int len);
      logic end_on_last;
      end_on_last = len > 0 && $urandom_range(0, 1) == 1;
      for (int n = 0; n < len; n++) begin
         if ($urandom_range(0, 19) == 0)
            send_item(md5_pkg::byte_type'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_item(md5_pkg::byte_type'($urandom_range(0, 255)), 1'b1,
                   end_on_last && n == len - 1);
      end
      if (!end_on_last) send_item(md5_pkg::byte_type'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   function automatic int pick_length();
      int edges [12] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
      if ($urandom_range(0, 9) < 3) return edges[$urandom_range(0, 11)];
      return $urandom_range(1, 40);
   endfunction

   initial begin
      req_bus.valid          = 1'b0;
      req_bus.data_byte      = '0;
      req_bus.byte_valid     = 1'b0;
      req_bus.end_of_message = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: ignored item, empty message, single extreme bytes, "abc"
      send_item(8'hff, 1'b0, 1'b0);
      send_item(8'h5a, 1'b0, 1'b1);
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'hff, 1'b1, 1'b1);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'ha5, 1'b0, 1'b1);
      wait_for_digests();

      // Random messages, lengths weighted toward padding boundaries
      while (items_sent < ItemTarget) begin
         if (items_sent >= ItemTarget / 2 && items_sent < ItemTarget / 2 + 40)
            wait_for_digests();
         if (items_sent >= QuietAfter) quiet_mode = 1'b1;
         send_message(pick_length());
      end

      wait_for_digests();
      repeat (DrainCycles) @(posedge clock);
      if (digests.fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
